// ===== hdl/alarm_latch_beeper_controller_assert.svh =====
// Assertion macros used by the checker of the alarm latch and beeper controller.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef ALARM_LATCH_BEEPER_CONTROLLER_ASSERT_SVH
`define ALARM_LATCH_BEEPER_CONTROLLER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ALB_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("alarm latch beeper controller check failed");

// The consequent must hold in the cycle after the antecedent.
`define ALB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("alarm latch beeper controller check failed");

`endif

// ===== hdl/alb_pkg.sv =====
package alb_pkg;

  localparam int unsigned NumAlarms = 15;

  localparam logic [1:0] KIND_TICK      = 2'd0;
  localparam logic [1:0] KIND_SET       = 2'd1;
  localparam logic [1:0] KIND_CLEAR     = 2'd2;
  localparam logic [1:0] KIND_CLEAR_ALL = 2'd3;

  localparam logic [1:0] MODE_OFF  = 2'd0;
  localparam logic [1:0] MODE_CONT = 2'd1;
  localparam logic [1:0] MODE_SLOW = 2'd2;
  localparam logic [1:0] MODE_FAST = 2'd3;

  localparam logic [1:0] REG_CLEAR_TEMP = 2'd0;
  localparam logic [1:0] REG_SLOW_HALF  = 2'd1;
  localparam logic [1:0] REG_FAST_HALF  = 2'd2;

  localparam logic [3:0] IDX_NONE = 4'd15;

  localparam logic [14:0] CONT_MASK = 15'h1C00;
  localparam logic [14:0] SLOW_MASK = 15'h2001;

  localparam logic signed [11:0] CLEAR_TEMP_RESET = 12'sd580;
  localparam logic [15:0]        SLOW_HALF_RESET  = 16'd1000;
  localparam logic [15:0]        FAST_HALF_RESET  = 16'd50;

  typedef struct packed {
    logic [1:0]         kind;
    logic [3:0]         alarm_index;
    logic [2:0]         enable_bits;
    logic [5:0]         relay_bits;
    logic [2:0]         contactor_bits;
    logic signed [11:0] temp_one;
    logic signed [11:0] temp_two;
    logic signed [11:0] temp_three;
    logic               supply_ok;
  } in_word_t;

  typedef struct packed {
    logic [14:0] active_mask;
    logic [3:0]  active_count;
    logic [3:0]  last_alarm;
    logic        alarm_line;
    logic [1:0]  beep_mode;
    logic        beep_on;
  } out_word_t;

endpackage

// ===== hdl/alarm_latch_beeper_controller.sv =====
// Alarm latch and beeper controller.
// Input channel: in_valid_i, in_stall_o and in_data_i carry one word per item:
// a 1 ms tick with pin samples, a set, a clear or a clear-all. A word is taken
// at a rising edge with in_valid_i high and in_stall_o low.
// Output channel: out_valid_o, out_stall_i and out_data_o return exactly one
// word per input word, showing the alarm bits, their count, the last alarm
// code, the alarm line and the buzzer mode and level after that item.
// A word taken at an edge has its result registered and valid from that edge;
// unless the receiver stalls, one word is taken every cycle; the state update
// and all fifteen clear conditions sit between state and output register.
// When the receiver stalls, the output register holds its word and in_stall_o
// rises, so no further input word is taken until the output word is gone.
// Configuration: cfg_valid_i, cfg_ready_o, cfg_index_i and cfg_data_i write the
// clear temperature and the two half periods; cfg_ready_o is always high.
// Reset clears all alarms, turns the buzzer off, empties the output register
// and loads the registers with 58.0 C, 1000 ticks and 50 ticks.
module alarm_latch_beeper_controller
  import alb_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_word_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_data_o,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  logic signed [11:0] clear_temp_q;
  logic [15:0]        slow_half_q;
  logic [15:0]        fast_half_q;

  logic [14:0] bits_q, bits_d;
  logic [3:0]  last_q, last_d;
  logic [1:0]  mode_q, mode_d;
  logic [15:0] elapsed_q, elapsed_d;
  logic        buzz_q, buzz_d;
  logic        line_q, line_d;

  logic      out_valid_q, out_valid_d;
  out_word_t out_word_q, out_word_d;

  logic        accept;
  logic [14:0] idx_bit;
  logic [15:0] el_inc, el_tick, half;
  logic        buzz_tick;
  logic        table_ok;
  logic [14:0] ok, clr, low_bit;
  logic        cont_seen;

  function automatic logic [1:0] mode_of(input logic [14:0] b);
    logic [1:0] m;
    if (b == '0) begin
      m = MODE_OFF;
    end else if ((b & CONT_MASK) != '0) begin
      m = MODE_CONT;
    end else if ((b & SLOW_MASK) != '0) begin
      m = MODE_SLOW;
    end else begin
      m = MODE_FAST;
    end
    return m;
  endfunction

  function automatic logic buzz_of(input logic [1:0] m, input logic cur);
    logic r;
    r = cur;
    if (m == MODE_OFF) begin
      r = 1'b0;
    end else if (m == MODE_CONT) begin
      r = 1'b1;
    end
    return r;
  endfunction

  function automatic logic [3:0] count_of(input logic [14:0] b);
    logic [3:0] n;
    n = '0;
    for (int i = 0; i < NumAlarms; i++) begin
      n = n + 4'(b[i]);
    end
    return n;
  endfunction

  assign accept      = in_valid_i && !in_stall_o;
  assign in_stall_o  = out_valid_q && out_stall_i;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_word_q;

  assign idx_bit = 15'd1 << in_data_i.alarm_index;

  always_comb begin
    table_ok = 1'b0;
    case (in_data_i.enable_bits)
      3'd0: table_ok = (in_data_i.relay_bits == 6'h00) && (in_data_i.contactor_bits == 3'd0);
      3'd1: table_ok = (in_data_i.relay_bits == 6'h03) && (in_data_i.contactor_bits == 3'd1);
      3'd2: table_ok = (in_data_i.relay_bits == 6'h0C) && (in_data_i.contactor_bits == 3'd2);
      3'd4: table_ok = (in_data_i.relay_bits == 6'h30) && (in_data_i.contactor_bits == 3'd4);
      default: table_ok = 1'b0;
    endcase
  end

  always_comb begin
    ok[0]    = (in_data_i.enable_bits & (in_data_i.enable_bits - 3'd1)) == 3'd0;
    ok[9:1]  = {9{table_ok}};
    ok[10]   = in_data_i.temp_one < clear_temp_q;
    ok[11]   = in_data_i.temp_two < clear_temp_q;
    ok[12]   = in_data_i.temp_three < clear_temp_q;
    ok[13]   = table_ok;
    ok[14]   = in_data_i.supply_ok;
  end

  // All clearable alarms are cleared on one tick; if a continuous alarm besides
  // the lowest cleared one was set, a remaining pulse mode keeps the level high.
  assign clr       = bits_q & ok;
  assign low_bit   = clr & (~clr + 15'd1);
  assign cont_seen = ((bits_q & ~low_bit & CONT_MASK) != '0);

  assign el_inc = (elapsed_q != 16'hFFFF) ? elapsed_q + 16'd1 : elapsed_q;
  assign half   = (mode_q == MODE_SLOW) ? slow_half_q : fast_half_q;

  always_comb begin
    el_tick   = el_inc;
    buzz_tick = buzz_q;
    if ((mode_q == MODE_SLOW || mode_q == MODE_FAST) && el_inc >= half) begin
      el_tick   = '0;
      buzz_tick = ~buzz_q;
    end
  end

  always_comb begin
    bits_d    = bits_q;
    last_d    = last_q;
    mode_d    = mode_q;
    elapsed_d = elapsed_q;
    buzz_d    = buzz_q;
    line_d    = line_q;
    case (in_data_i.kind)
      KIND_SET: begin
        if (in_data_i.alarm_index != IDX_NONE) begin
          bits_d    = bits_q | idx_bit;
          last_d    = in_data_i.alarm_index + 4'd1;
          line_d    = 1'b1;
          mode_d    = mode_of(bits_d);
          elapsed_d = '0;
          buzz_d    = buzz_of(mode_d, buzz_q);
        end
      end
      KIND_CLEAR: begin
        if (in_data_i.alarm_index != IDX_NONE) begin
          bits_d = bits_q & ~idx_bit;
          if (bits_d == '0) begin
            last_d = '0;
            line_d = 1'b0;
          end
          mode_d    = mode_of(bits_d);
          elapsed_d = '0;
          buzz_d    = buzz_of(mode_d, buzz_q);
        end
      end
      KIND_CLEAR_ALL: begin
        bits_d    = '0;
        last_d    = '0;
        line_d    = 1'b0;
        mode_d    = MODE_OFF;
        elapsed_d = '0;
        buzz_d    = 1'b0;
      end
      KIND_TICK: begin
        elapsed_d = el_tick;
        buzz_d    = buzz_tick;
        if (clr != '0) begin
          bits_d = bits_q & ~clr;
          if (bits_d == '0) begin
            last_d = '0;
            line_d = 1'b0;
          end
          mode_d    = mode_of(bits_d);
          elapsed_d = '0;
          buzz_d    = buzz_of(mode_d, cont_seen | buzz_tick);
        end
      end
      default: begin
        bits_d = bits_q;
      end
    endcase
  end

  always_comb begin
    out_word_d.active_mask  = bits_d;
    out_word_d.active_count = count_of(bits_d);
    out_word_d.last_alarm   = last_d;
    out_word_d.alarm_line   = line_d;
    out_word_d.beep_mode    = mode_d;
    out_word_d.beep_on      = buzz_d;
    out_valid_d = accept || (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_temp_q <= CLEAR_TEMP_RESET;
      slow_half_q  <= SLOW_HALF_RESET;
      fast_half_q  <= FAST_HALF_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_CLEAR_TEMP: clear_temp_q <= cfg_data_i[11:0];
        REG_SLOW_HALF:  slow_half_q  <= cfg_data_i;
        REG_FAST_HALF:  fast_half_q  <= cfg_data_i;
        default: begin
          slow_half_q <= slow_half_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bits_q      <= '0;
      last_q      <= '0;
      mode_q      <= MODE_OFF;
      elapsed_q   <= '0;
      buzz_q      <= 1'b0;
      line_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (accept) begin
        bits_q    <= bits_d;
        last_q    <= last_d;
        mode_q    <= mode_d;
        elapsed_q <= elapsed_d;
        buzz_q    <= buzz_d;
        line_q    <= line_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_word_q <= out_word_d;
    end
  end

endmodule

// ===== hdl/alb_checker.sv =====
`include "alarm_latch_beeper_controller_assert.svh"

module alb_checker
  import alb_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_word_t out_data_o
);

  `ALB_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o)
  `ALB_ASSERT_NOW(a_stall_needs_word, in_stall_o, out_valid_o && out_stall_i)
  `ALB_ASSERT_NOW(a_count_matches, out_valid_o, $countones(out_data_o.active_mask) == out_data_o.active_count)
  `ALB_ASSERT_NOW(a_idle_when_clear, out_valid_o && out_data_o.active_mask == '0, out_data_o.last_alarm == '0 && !out_data_o.alarm_line && out_data_o.beep_mode == MODE_OFF && !out_data_o.beep_on)
  `ALB_ASSERT_NOW(a_cont_sounds, out_valid_o && out_data_o.beep_mode == MODE_CONT, out_data_o.beep_on)

endmodule

bind alarm_latch_beeper_controller alb_checker u_alb_checker (.*);
